FILE: design/tlbfr_pkg.sv
package tlbfr_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PID_BITS_DEF    = 8;
    localparam int PAGE_BITS_DEF   = 12;
    localparam int FRAME_BITS_DEF  = 16;

    localparam int CFG_W = 5;
    localparam int SLOT_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOOKUP,
        S_FIND,
        S_INSERT,
        S_INV,
        S_COMPACT,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOOKUP_STEP,
        OP_FIND_STEP,
        OP_INSERT,
        OP_INV_STEP,
        OP_COMPACT_STEP,
        OP_COMPACT_END,
        OP_FLUSH,
        OP_RESULT
    } op_t;

    typedef struct packed {
        cmd_t cmd;
        logic match;
        logic slot_free;
        logic scan_last;
        logic queue_room;
        logic comp_done;
        logic out_free;
    } status_t;

endpackage

FILE: design/tlb_fifo_replacement.sv
// channel | ports                                   | direction
// input   | s_valid s_ready s_command s_process_id  | in
//         | s_page s_frame_in                       |
// result  | m_valid m_ready m_hit m_frame_out m_slot| out
//         | m_evicted m_victim_pid/page/frame       |
// config  | cfg_valid cfg_ready cfg_data            | in
//
// one command at a time; the slot scan and queue compaction each take one slot per cycle
// lookup scans until a match or the last slot in use; insert scans for a free slot
// only if the queue has room, then writes; invalidate scans all, then compacts the queue
// synchronous active-low reset clears valid bits, queue count and slots in use (16)
// a stalled result sits in the output register; the next command is accepted meanwhile
module tlb_fifo_replacement #(
    parameter int PID_BITS    = tlbfr_pkg::PID_BITS_DEF,
    parameter int PAGE_BITS   = tlbfr_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS  = tlbfr_pkg::FRAME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic [PID_BITS-1:0]          s_process_id,
    input  logic [PAGE_BITS-1:0]         s_page,
    input  logic [FRAME_BITS-1:0]        s_frame_in,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tlbfr_pkg::CFG_W-1:0]  cfg_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [FRAME_BITS-1:0]        m_frame_out,
    output logic [tlbfr_pkg::SLOT_W-1:0] m_slot,
    output logic                         m_evicted,
    output logic [PID_BITS-1:0]          m_victim_pid,
    output logic [PAGE_BITS-1:0]         m_victim_page,
    output logic [FRAME_BITS-1:0]        m_victim_frame
);

    tlbfr_pkg::op_t     op;
    tlbfr_pkg::status_t status;

    tlbfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    tlbfr_dpath #(
        .PID_BITS    (PID_BITS),
        .PAGE_BITS   (PAGE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_command      (s_command),
        .s_process_id   (s_process_id),
        .s_page         (s_page),
        .s_frame_in     (s_frame_in),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .op             (op),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame_out    (m_frame_out),
        .m_slot         (m_slot),
        .m_evicted      (m_evicted),
        .m_victim_pid   (m_victim_pid),
        .m_victim_page  (m_victim_page),
        .m_victim_frame (m_victim_frame)
    );

endmodule

FILE: design/tlbfr_ctrl.sv
module tlbfr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tlbfr_pkg::status_t status,
    output tlbfr_pkg::op_t     op
);

    tlbfr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlbfr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = tlbfr_pkg::OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            tlbfr_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = tlbfr_pkg::OP_LOAD;
                    state_next = tlbfr_pkg::S_DISPATCH;
                end
            end
            tlbfr_pkg::S_DISPATCH: begin
                case (status.cmd)
                    tlbfr_pkg::CMD_LOOKUP: state_next = tlbfr_pkg::S_LOOKUP;
                    tlbfr_pkg::CMD_INSERT: begin
                        state_next = status.queue_room ? tlbfr_pkg::S_FIND
                                                       : tlbfr_pkg::S_INSERT;
                    end
                    tlbfr_pkg::CMD_INVAL:  state_next = tlbfr_pkg::S_INV;
                    tlbfr_pkg::CMD_FLUSH: begin
                        op         = tlbfr_pkg::OP_FLUSH;
                        state_next = tlbfr_pkg::S_RESP;
                    end
                    default: state_next = tlbfr_pkg::S_RESP;
                endcase
            end
            tlbfr_pkg::S_LOOKUP: begin
                op = tlbfr_pkg::OP_LOOKUP_STEP;
                if (status.match || status.scan_last) begin
                    state_next = tlbfr_pkg::S_RESP;
                end
            end
            tlbfr_pkg::S_FIND: begin
                op = tlbfr_pkg::OP_FIND_STEP;
                if (status.slot_free || status.scan_last) begin
                    state_next = tlbfr_pkg::S_INSERT;
                end
            end
            tlbfr_pkg::S_INSERT: begin
                op         = tlbfr_pkg::OP_INSERT;
                state_next = tlbfr_pkg::S_RESP;
            end
            tlbfr_pkg::S_INV: begin
                op = tlbfr_pkg::OP_INV_STEP;
                if (status.scan_last) begin
                    state_next = tlbfr_pkg::S_COMPACT;
                end
            end
            tlbfr_pkg::S_COMPACT: begin
                if (status.comp_done) begin
                    op         = tlbfr_pkg::OP_COMPACT_END;
                    state_next = tlbfr_pkg::S_RESP;
                end else begin
                    op = tlbfr_pkg::OP_COMPACT_STEP;
                end
            end
            tlbfr_pkg::S_RESP: begin
                if (status.out_free) begin
                    op         = tlbfr_pkg::OP_RESULT;
                    state_next = tlbfr_pkg::S_IDLE;
                end
            end
            default: state_next = tlbfr_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: design/tlbfr_dpath.sv
module tlbfr_dpath #(
    parameter int PID_BITS    = tlbfr_pkg::PID_BITS_DEF,
    parameter int PAGE_BITS   = tlbfr_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS  = tlbfr_pkg::FRAME_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [1:0]                  s_command,
    input  logic [PID_BITS-1:0]         s_process_id,
    input  logic [PAGE_BITS-1:0]        s_page,
    input  logic [FRAME_BITS-1:0]       s_frame_in,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tlbfr_pkg::CFG_W-1:0] cfg_data,
    input  tlbfr_pkg::op_t              op,
    output tlbfr_pkg::status_t          status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [FRAME_BITS-1:0]       m_frame_out,
    output logic [tlbfr_pkg::SLOT_W-1:0] m_slot,
    output logic                        m_evicted,
    output logic [PID_BITS-1:0]         m_victim_pid,
    output logic [PAGE_BITS-1:0]        m_victim_page,
    output logic [FRAME_BITS-1:0]       m_victim_frame
);

    localparam int E     = tlbfr_pkg::TLB_ENTRIES_DEF;
    localparam int IDX_W = (E > 1) ? $clog2(E) : 1;
    localparam int CNT_W = $clog2(E + 1);
    localparam int SlotW = tlbfr_pkg::SLOT_W;

    logic [tlbfr_pkg::CFG_W-1:0] cfg_reg;
    tlbfr_pkg::cmd_t             cmd_reg;
    logic [PID_BITS-1:0]         pid_reg;
    logic [PAGE_BITS-1:0]        page_reg;
    logic [FRAME_BITS-1:0]       frame_reg;

    logic [E-1:0]          valid_reg;
    logic [E-1:0]          drop_reg;
    logic [PID_BITS-1:0]   pid_mem   [E];
    logic [PAGE_BITS-1:0]  page_mem  [E];
    logic [FRAME_BITS-1:0] frame_mem [E];

    logic [IDX_W-1:0] order_reg [E];
    logic [IDX_W-1:0] order_shift [E];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] rd_reg;
    logic [CNT_W-1:0] wr_reg;
    logic [IDX_W-1:0] target_reg;
    logic             found_reg;

    logic                  res_hit;
    logic [FRAME_BITS-1:0] res_frame;
    logic [IDX_W-1:0]      res_slot;
    logic                  res_ev;
    logic [PID_BITS-1:0]   res_vpid;
    logic [PAGE_BITS-1:0]  res_vpage;
    logic [FRAME_BITS-1:0] res_vframe;

    logic [CNT_W-1:0] n_used;
    logic [IDX_W-1:0] cur;
    logic             match;
    logic             last;
    logic [IDX_W-1:0] tgt;
    logic [IDX_W-1:0] rd_slot;
    logic [IDX_W-1:0] tail_idx;

    // slots in use clamped to 1..TLB_ENTRIES
    always_comb begin
        if (cfg_reg == '0) begin
            n_used = CNT_W'(1);
        end else if (32'(cfg_reg) > 32'(E)) begin
            n_used = CNT_W'(E);
        end else begin
            n_used = CNT_W'(cfg_reg);
        end
    end

    assign cur      = idx_reg[IDX_W-1:0];
    assign match    = valid_reg[cur] && (pid_mem[cur] == pid_reg) && (page_mem[cur] == page_reg);
    assign last     = (idx_reg == n_used - 1'b1);
    assign rd_slot  = order_reg[rd_reg[IDX_W-1:0]];
    assign tail_idx = count_reg[IDX_W-1:0] - 1'b1;

    // replacement takes the queue head, or slot 0 with an empty queue
    always_comb begin
        if (found_reg) begin
            tgt = target_reg;
        end else if (count_reg != '0) begin
            tgt = order_reg[0];
        end else begin
            tgt = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < E - 1; k++) begin
            order_shift[k] = order_reg[k+1];
        end
        order_shift[E-1] = order_reg[E-1];
    end

    assign status.cmd        = cmd_reg;
    assign status.match      = match;
    assign status.slot_free  = !valid_reg[cur];
    assign status.scan_last  = last;
    assign status.queue_room = (count_reg < n_used);
    assign status.comp_done  = (rd_reg >= count_reg);
    assign status.out_free   = !m_valid || m_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= tlbfr_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            cfg_reg <= cfg_data;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            drop_reg  <= '0;
        end else begin
            case (op)
                tlbfr_pkg::OP_LOAD: begin
                    found_reg <= 1'b0;
                    idx_reg   <= '0;
                    rd_reg    <= '0;
                    wr_reg    <= '0;
                    drop_reg  <= '0;
                end
                tlbfr_pkg::OP_LOOKUP_STEP: begin
                    if (!match && !last) idx_reg <= idx_reg + 1'b1;
                end
                tlbfr_pkg::OP_FIND_STEP: begin
                    if (!valid_reg[cur]) begin
                        found_reg <= 1'b1;
                    end else if (!last) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                tlbfr_pkg::OP_INSERT: begin
                    valid_reg[tgt] <= 1'b1;
                    if (found_reg || count_reg == '0) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                tlbfr_pkg::OP_INV_STEP: begin
                    if (match) begin
                        valid_reg[cur] <= 1'b0;
                        drop_reg[cur]  <= 1'b1;
                    end
                    if (!last) idx_reg <= idx_reg + 1'b1;
                end
                tlbfr_pkg::OP_COMPACT_STEP: begin
                    if (!drop_reg[rd_slot]) wr_reg <= wr_reg + 1'b1;
                    rd_reg <= rd_reg + 1'b1;
                end
                tlbfr_pkg::OP_COMPACT_END: begin
                    count_reg <= wr_reg;
                end
                tlbfr_pkg::OP_FLUSH: begin
                    valid_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload: latched item, entries, order queue and result
    always_ff @(posedge aclk) begin
        case (op)
            tlbfr_pkg::OP_LOAD: begin
                cmd_reg    <= tlbfr_pkg::cmd_t'(s_command);
                pid_reg    <= s_process_id;
                page_reg   <= s_page;
                frame_reg  <= s_frame_in;
                res_hit    <= 1'b0;
                res_frame  <= '0;
                res_slot   <= '0;
                res_ev     <= 1'b0;
                res_vpid   <= '0;
                res_vpage  <= '0;
                res_vframe <= '0;
            end
            tlbfr_pkg::OP_LOOKUP_STEP: begin
                if (match) begin
                    res_hit   <= 1'b1;
                    res_frame <= frame_mem[cur];
                    res_slot  <= cur;
                end
            end
            tlbfr_pkg::OP_FIND_STEP: begin
                if (!valid_reg[cur]) target_reg <= cur;
            end
            tlbfr_pkg::OP_INSERT: begin
                pid_mem[tgt]   <= pid_reg;
                page_mem[tgt]  <= page_reg;
                frame_mem[tgt] <= frame_reg;
                res_slot       <= tgt;
                if (valid_reg[tgt]) begin
                    res_ev     <= 1'b1;
                    res_vpid   <= pid_mem[tgt];
                    res_vpage  <= page_mem[tgt];
                    res_vframe <= frame_mem[tgt];
                end
                if (found_reg || count_reg == '0) begin
                    order_reg[count_reg[IDX_W-1:0]] <= tgt;
                end else begin
                    // pop the head and push the same slot at the tail
                    for (int k = 0; k < E; k++) begin
                        if (IDX_W'(k) == tail_idx) begin
                            order_reg[k] <= tgt;
                        end else begin
                            order_reg[k] <= order_shift[k];
                        end
                    end
                end
            end
            tlbfr_pkg::OP_COMPACT_STEP: begin
                if (!drop_reg[rd_slot]) order_reg[wr_reg[IDX_W-1:0]] <= rd_slot;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (op == tlbfr_pkg::OP_RESULT) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == tlbfr_pkg::OP_RESULT) begin
            m_hit          <= res_hit;
            m_frame_out    <= res_frame;
            m_slot         <= SlotW'(res_slot);
            m_evicted      <= res_ev;
            m_victim_pid   <= res_vpid;
            m_victim_page  <= res_vpage;
            m_victim_frame <= res_vframe;
        end
    end

endmodule

FILE: design/tlbfr_checker.sv
module tlbfr_checker #(
    parameter int PID_BITS   = tlbfr_pkg::PID_BITS_DEF,
    parameter int PAGE_BITS  = tlbfr_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS = tlbfr_pkg::FRAME_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit,
    input logic [FRAME_BITS-1:0] m_frame_out,
    input logic                  m_evicted,
    input logic [PID_BITS-1:0]   m_victim_pid,
    input logic [PAGE_BITS-1:0]  m_victim_page,
    input logic [FRAME_BITS-1:0] m_victim_frame
);

    // a hit comes from a lookup, an eviction from an insert
    a_hit_xor_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("hit and evicted together");

    a_miss_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_frame_out == '0))
        else $error("frame shown without a hit");

    a_no_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |->
        (m_victim_pid == '0 && m_victim_page == '0 && m_victim_frame == '0))
        else $error("victim fields without an eviction");

    // a command is never taken in two consecutive cycles
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transfer");

endmodule

bind tlb_fifo_replacement tlbfr_checker #(
    .PID_BITS   (PID_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
) u_tlbfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hit          (m_hit),
    .m_frame_out    (m_frame_out),
    .m_evicted      (m_evicted),
    .m_victim_pid   (m_victim_pid),
    .m_victim_page  (m_victim_page),
    .m_victim_frame (m_victim_frame)
);
